// File: hdl/oqd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oqd_pkg;

    // Queue geometry.
    localparam int DEPTH        = 16;
    localparam int HANDLE_WIDTH = 32;
    localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W        = $clog2(DEPTH + 1);

    // Opcodes of a request.
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_DELETE     = 3'd3;
    localparam logic [2:0] OP_LIST       = 3'd4;

    // Response status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_REJECT     = 2'd1;
    localparam logic [1:0] ST_EMPTY_LIST = 2'd2;

    // Commands broadcast to every cell of the chain.
    localparam logic [2:0] CMD_HOLD       = 3'd0;
    localparam logic [2:0] CMD_COMPARE    = 3'd1;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd3;
    localparam logic [2:0] CMD_POP        = 3'd4;
    localparam logic [2:0] CMD_DELETE     = 3'd5;
    localparam logic [2:0] CMD_ROTATE     = 3'd6;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [HANDLE_WIDTH-1:0] handle_in;
    } oqd_req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [HANDLE_WIDTH-1:0] handle_out;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } oqd_rsp_t;

    typedef struct packed {
        logic [2:0]              cmd;
        logic [HANDLE_WIDTH-1:0] handle;
        logic [CNT_W-1:0]        count;
    } oqd_ctl_t;

endpackage

`default_nettype wire

// File: hdl/oqd_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the queue. Slot 0 is the head; data moves toward the head on
// removals and toward the tail on a push at the front.
module oqd_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [oqd_pkg::IDX_W-1:0]         idx,
    input  wire oqd_pkg::oqd_ctl_t                 ctl,
    input  wire logic [oqd_pkg::HANDLE_WIDTH-1:0]  left_data,
    input  wire logic [oqd_pkg::HANDLE_WIDTH-1:0]  right_data,
    input  wire logic [oqd_pkg::HANDLE_WIDTH-1:0]  head_data,
    input  wire logic                              seen_in,
    output logic [oqd_pkg::HANDLE_WIDTH-1:0]       data,
    output logic                                   seen_out
);
    import oqd_pkg::*;

    logic [HANDLE_WIDTH-1:0] data_reg;
    logic [HANDLE_WIDTH-1:0] data_next;
    logic                    match_reg;
    logic                    match_next;
    logic [CNT_W-1:0]        idx_ext;
    logic                    occupied;

    assign idx_ext  = CNT_W'(idx);
    assign occupied = (idx_ext < ctl.count);
    assign seen_out = seen_in | match_reg;
    assign data     = data_reg;

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        case (ctl.cmd)
            CMD_COMPARE:
            begin
                match_next = occupied && (data_reg == ctl.handle);
            end
            CMD_PUSH_BACK:
            begin
                if (idx_ext == ctl.count)
                begin
                    data_next = ctl.handle;
                end
            end
            CMD_PUSH_FRONT:
            begin
                data_next = left_data;
            end
            CMD_POP:
            begin
                data_next = right_data;
            end
            CMD_DELETE:
            begin
                // Every slot at or behind the first match closes the gap.
                if (seen_out)
                begin
                    data_next = right_data;
                end
            end
            CMD_ROTATE:
            begin
                if (idx_ext == ctl.count - CNT_W'(1))
                begin
                    data_next = head_data;
                end
                else
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ordered_queue_with_delete.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered queue of nonzero handles with push back, push front, pop front,
// delete of the first matching handle and a full listing.
// Requests enter on req (opcode, handle_in) with req_valid/req_ready; results
// leave on rsp (status, handle_out, count, last) with rsp_valid/rsp_ready.
// The block works on one request at a time. A request is taken only while the
// block is idle; the control then decides the operation in its execute state
// and offers the single result in its response state, where it waits while
// the receiver stalls. A list of N entries offers one entry per cycle while
// the receiver holds rsp_ready high, head first, with last set on the tail;
// each transfer rotates the chain of slots by one, so after N transfers the
// order is restored. A delete compares every slot against the handle in the
// cycle of the request transfer, and a ripple of match flags along the chain
// picks the first match. While the receiver holds rsp_ready low the result
// waits in place and no new request is taken. Reset empties the queue (count
// zero) and returns the control to idle; slot contents are not cleared, since
// a slot is never read before it is written.
module ordered_queue_with_delete (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire oqd_pkg::oqd_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output oqd_pkg::oqd_rsp_t      rsp
);
    import oqd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [2:0]              op_reg, op_next;
    logic [HANDLE_WIDTH-1:0] handle_reg, handle_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [1:0]              status_reg, status_next;
    logic [HANDLE_WIDTH-1:0] hout_reg, hout_next;
    logic [IDX_W-1:0]        list_idx_reg, list_idx_next;

    oqd_ctl_t                ctl;
    logic [HANDLE_WIDTH-1:0] cell_data [DEPTH];
    logic                    seen [DEPTH+1];
    logic                    list_last;
    logic                    handle_zero;
    logic                    full;
    logic                    empty;

    // The chain of slots.
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [HANDLE_WIDTH-1:0] left_d;
        logic [HANDLE_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_head
            assign left_d = ctl.handle;
        end
        else
        begin : g_body
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_d = '0;
        end
        else
        begin : g_inner
            assign right_d = cell_data[i+1];
        end

        oqd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (IDX_W'(i)),
            .ctl        (ctl),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .seen_in    (seen[i]),
            .data       (cell_data[i]),
            .seen_out   (seen[i+1])
        );
    end

    assign handle_zero = (handle_reg == '0);
    assign full        = (count_reg == CNT_W'(DEPTH));
    assign empty       = (count_reg == '0);
    assign list_last   = (CNT_W'(list_idx_reg) == count_reg - CNT_W'(1));

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_RESP) || (state_reg == S_LIST);

    // A listed entry is read straight from the head slot.
    always_comb
    begin
        if (state_reg == S_LIST)
        begin
            rsp.status     = ST_OK;
            rsp.handle_out = cell_data[0];
            rsp.count      = count_reg;
            rsp.last       = list_last;
        end
        else
        begin
            rsp.status     = status_reg;
            rsp.handle_out = hout_reg;
            rsp.count      = count_reg;
            rsp.last       = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        handle_next   = handle_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        hout_next     = hout_reg;
        list_idx_next = list_idx_reg;
        ctl.cmd       = CMD_HOLD;
        ctl.handle    = handle_reg;
        ctl.count     = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Slots compare against the incoming handle while idle, so the
                // match flags are ready when a delete is decided.
                ctl.cmd    = CMD_COMPARE;
                ctl.handle = req.handle_in;
                if (req_valid)
                begin
                    op_next     = req.opcode;
                    handle_next = req.handle_in;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_REJECT;
                hout_next   = '0;
                state_next  = S_RESP;
                case (op_reg)
                    OP_PUSH_BACK:
                    begin
                        if (!handle_zero && !full)
                        begin
                            ctl.cmd     = CMD_PUSH_BACK;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_OK;
                        end
                    end
                    OP_PUSH_FRONT:
                    begin
                        if (!handle_zero && !full)
                        begin
                            ctl.cmd     = CMD_PUSH_FRONT;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_OK;
                        end
                    end
                    OP_POP_FRONT:
                    begin
                        if (!empty)
                        begin
                            ctl.cmd     = CMD_POP;
                            count_next  = count_reg - CNT_W'(1);
                            status_next = ST_OK;
                            hout_next   = cell_data[0];
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!handle_zero && seen[DEPTH])
                        begin
                            ctl.cmd     = CMD_DELETE;
                            count_next  = count_reg - CNT_W'(1);
                            status_next = ST_OK;
                        end
                    end
                    OP_LIST:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY_LIST;
                        end
                        else
                        begin
                            list_idx_next = '0;
                            state_next    = S_LIST;
                        end
                    end
                    default:
                    begin
                        status_next = ST_REJECT;
                    end
                endcase
            end
            S_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (rsp_ready)
                begin
                    ctl.cmd       = CMD_ROTATE;
                    list_idx_next = list_idx_reg + IDX_W'(1);
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        handle_reg <= handle_next;
        status_reg <= status_next;
        hout_reg   <= hout_next;
    end

endmodule

`default_nettype wire

// File: hdl/oqd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module oqd_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_ready,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_ready,
    input  wire oqd_pkg::oqd_rsp_t rsp
);
    import oqd_pkg::*;

    // The block takes no request while a result is still on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while a result is pending");

    // A stalled result holds still.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // The reported count never exceeds the capacity.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.count <= CNT_W'(DEPTH))
        else $error("count above capacity");

    // A rejection or an empty list carries no handle.
    a_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_REJECT || rsp.status == ST_EMPTY_LIST)
        |-> rsp.handle_out == '0 && rsp.last)
        else $error("handle on a rejection or empty list");

    // An empty list reports an empty queue.
    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY_LIST |-> rsp.count == '0)
        else $error("empty list with nonzero count");

endmodule

bind ordered_queue_with_delete oqd_checker u_oqd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
